FILE: rtl/tkh_pkg.sv
// ----------------------------------------------------------------------------
// tkh_pkg: shared types and constants of the top-K heap selector
//
// Heap geometry, entry and word layouts, sequencer states and the layout of
// the configuration register space.
// ----------------------------------------------------------------------------
package tkh_pkg;

  // Heap capacity and kept index width.
  localparam int MAX_K      = 16;
  localparam int INDEX_BITS = 20;

  // Fixed field widths of the channel words.
  localparam int DIST_W     = 32;
  localparam int CIDX_W     = 20;
  localparam int KCFG_W     = 5;

  // Index bits that survive both the index mask and the field width.
  localparam int IDX_KEEP   = (INDEX_BITS < CIDX_W) ? INDEX_BITS : CIDX_W;

  // Heap position, fill count and child position widths.
  localparam int AW         = (MAX_K > 1) ? $clog2(MAX_K) : 1;
  localparam int KB         = $clog2(MAX_K + 1);
  localparam int CW         = KB + 1;

  // Configuration port layout.
  localparam int              PADDR_W   = 3;
  localparam int              REG_IDX_W = PADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_K_IDX = '0;
  localparam logic [KCFG_W-1:0]    K_RESET   = KCFG_W'(16);

  // One heap entry.
  typedef struct packed {
    logic [DIST_W-1:0]   distance;
    logic [IDX_KEEP-1:0] idx;
  } entry_t;

  // Candidate word.
  typedef struct packed {
    logic [DIST_W-1:0] cand_distance;
    logic [CIDX_W-1:0] cand_index;
    logic              query_end;
  } cand_word_t;

  // Result word.
  typedef struct packed {
    logic [DIST_W-1:0] out_distance;
    logic [CIDX_W-1:0] out_index;
    logic              out_last;
  } res_word_t;

  // Decision of the shared compare unit.
  typedef struct packed {
    logic pick_b;
    logic cur_gt;
    logic cur_lt;
  } cmp_res_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ROOT_RD,
    ST_ROOT_CMP,
    ST_UP_RD,
    ST_UP_CMP,
    ST_DN_RD,
    ST_DN_CMP,
    ST_FINISH,
    ST_DR_RD,
    ST_DR_EMIT
  } state_t;

endpackage

FILE: rtl/top_k_smallest_max_heap.sv
// ----------------------------------------------------------------------------
// top_k_smallest_max_heap: K nearest candidates of a query by a max-heap
//
// Keeps the k_in_use smallest distances of the current query and drains
// them largest first when the query ends.
// ----------------------------------------------------------------------------
// Usage:
// Candidate words enter on cand_valid/cand_ready, one at a time; cand_ready is
// high only while the sequencer is idle. A candidate is appended and sifted up,
// compared with the root and sifted down, or dropped. Each heap level is a
// memory read, then a compare and write. A candidate with query_end set then
// drains the heap: each result word fetches the root and the tail, then sifts
// the tail down from the root level by level and places it.
// Result words leave on res_valid/res_ready from an output register; when the
// receiver stalls the drain waits at the next result and holds the heap.
// out_last marks the final word. k_in_use (byte address 0) sets K; zero acts
// as one and values above MAX_K act as MAX_K. Reset empties the heap, sets K
// to 16 and needs no clearing pass since only filled entries are ever read.
// ----------------------------------------------------------------------------
module top_k_smallest_max_heap (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cand_valid,
  output logic                          cand_ready,
  input  tkh_pkg::cand_word_t           cand,
  output logic                          res_valid,
  input  logic                          res_ready,
  output tkh_pkg::res_word_t            res,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tkh_pkg::PADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  // Control registers.
  tkh_pkg::state_t               state, state_next;
  logic [tkh_pkg::KB-1:0]        kept, kept_next;
  logic                          draining, draining_next;
  logic                          res_valid_next;
  logic [tkh_pkg::KCFG_W-1:0]    k_reg;

  // Datapath registers.
  tkh_pkg::entry_t               cur, cur_next;
  logic                          last_q, last_q_next;
  logic [tkh_pkg::AW-1:0]        hole, hole_next;
  logic [tkh_pkg::AW-1:0]        par, par_next;
  logic [tkh_pkg::CW-1:0]        child, child_next;
  logic                          rv_q, rv_q_next;
  tkh_pkg::res_word_t            res_next;

  // Memory and compare unit connections.
  logic                          mem_we, mem_re;
  logic [tkh_pkg::AW-1:0]        mem_waddr, mem_raddr0, mem_raddr1;
  tkh_pkg::entry_t               mem_wdata, rdata0, rdata1;
  tkh_pkg::cmp_res_t             cmp;
  logic                          cmp_b_valid;

  // Derived values.
  logic [tkh_pkg::KB-1:0]        k_eff;
  logic [tkh_pkg::CW-1:0]        c_left, c_right;
  logic                          cand_acc, out_free, cfg_wr;

  // --------------------------------------------------------------------------
  // Configuration port.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite
                  && (paddr[tkh_pkg::PADDR_W-1:2] == tkh_pkg::REG_K_IDX);
  assign prdata = (paddr[tkh_pkg::PADDR_W-1:2] == tkh_pkg::REG_K_IDX)
                  ? 32'(k_reg) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      k_reg <= tkh_pkg::K_RESET;
    end else if (cfg_wr) begin
      k_reg <= pwdata[tkh_pkg::KCFG_W-1:0];
    end
  end

  // Effective K, clamped to 1..MAX_K.
  always_comb begin
    if (k_reg == '0) begin
      k_eff = tkh_pkg::KB'(1);
    end else if (32'(k_reg) > 32'(tkh_pkg::MAX_K)) begin
      k_eff = tkh_pkg::KB'(tkh_pkg::MAX_K);
    end else begin
      k_eff = tkh_pkg::KB'(k_reg);
    end
  end

  // --------------------------------------------------------------------------
  // Storage and shared compare unit.
  tkh_heap_mem u_mem (
    .clk    (clk),
    .we     (mem_we),
    .waddr  (mem_waddr),
    .wdata  (mem_wdata),
    .re     (mem_re),
    .raddr0 (mem_raddr0),
    .raddr1 (mem_raddr1),
    .rdata0 (rdata0),
    .rdata1 (rdata1)
  );

  assign cmp_b_valid = (state == tkh_pkg::ST_DN_CMP) && rv_q;

  tkh_cmp u_cmp (
    .cur_dist (cur.distance),
    .a_dist   (rdata0.distance),
    .b_dist   (rdata1.distance),
    .b_valid  (cmp_b_valid),
    .res      (cmp)
  );

  // --------------------------------------------------------------------------
  // Handshake helpers and child positions of the hole.
  assign cand_ready = (state == tkh_pkg::ST_IDLE);
  assign cand_acc   = cand_valid && cand_ready;
  assign out_free   = !res_valid || res_ready;
  assign c_left     = (tkh_pkg::CW'(hole) << 1) + tkh_pkg::CW'(1);
  assign c_right    = c_left + tkh_pkg::CW'(1);

  // --------------------------------------------------------------------------
  // Sequencer state and control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= tkh_pkg::ST_IDLE;
      kept      <= '0;
      draining  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      kept      <= kept_next;
      draining  <= draining_next;
      res_valid <= res_valid_next;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    cur    <= cur_next;
    last_q <= last_q_next;
    hole   <= hole_next;
    par    <= par_next;
    child  <= child_next;
    rv_q   <= rv_q_next;
    res    <= res_next;
  end

  // Heap position of the right child of the registered left child.
  function automatic logic [tkh_pkg::AW-1:0] c_plus(input logic [tkh_pkg::CW-1:0] c);
    logic [tkh_pkg::CW-1:0] r;
    r = c + tkh_pkg::CW'(1);
    return r[tkh_pkg::AW-1:0];
  endfunction

  // --------------------------------------------------------------------------
  // Next state, memory control and output word.
  always_comb begin
    state_next     = state;
    kept_next      = kept;
    draining_next  = draining;
    cur_next       = cur;
    last_q_next    = last_q;
    hole_next      = hole;
    par_next       = par;
    child_next     = child;
    rv_q_next      = rv_q;
    res_next       = res;
    res_valid_next = res_valid && !res_ready;
    mem_we         = 1'b0;
    mem_waddr      = hole;
    mem_wdata      = cur;
    mem_re         = 1'b0;
    mem_raddr0     = '0;
    mem_raddr1     = '0;

    unique case (state)
      tkh_pkg::ST_IDLE: begin
        if (cand_acc) begin
          cur_next.distance = cand.cand_distance;
          cur_next.idx      = cand.cand_index[tkh_pkg::IDX_KEEP-1:0];
          last_q_next       = cand.query_end;
          if (kept < k_eff) begin
            // Room left: append at the end and sift up.
            hole_next  = kept[tkh_pkg::AW-1:0];
            kept_next  = kept + tkh_pkg::KB'(1);
            state_next = tkh_pkg::ST_UP_RD;
          end else begin
            state_next = tkh_pkg::ST_ROOT_RD;
          end
        end
      end

      tkh_pkg::ST_ROOT_RD: begin
        mem_re     = 1'b1;
        state_next = tkh_pkg::ST_ROOT_CMP;
      end

      tkh_pkg::ST_ROOT_CMP: begin
        // Full heap: replace the root only with a strictly smaller distance.
        if (cmp.cur_lt) begin
          hole_next  = '0;
          state_next = tkh_pkg::ST_DN_RD;
        end else begin
          state_next = tkh_pkg::ST_FINISH;
        end
      end

      tkh_pkg::ST_UP_RD: begin
        if (hole == '0) begin
          mem_we     = 1'b1;
          state_next = tkh_pkg::ST_FINISH;
        end else begin
          par_next   = (hole - tkh_pkg::AW'(1)) >> 1;
          mem_re     = 1'b1;
          mem_raddr0 = (hole - tkh_pkg::AW'(1)) >> 1;
          state_next = tkh_pkg::ST_UP_CMP;
        end
      end

      tkh_pkg::ST_UP_CMP: begin
        // The moving entry rises only above a strictly smaller parent.
        mem_we = 1'b1;
        if (cmp.cur_gt) begin
          mem_wdata  = rdata0;
          hole_next  = par;
          state_next = tkh_pkg::ST_UP_RD;
        end else begin
          state_next = tkh_pkg::ST_FINISH;
        end
      end

      tkh_pkg::ST_DN_RD: begin
        if (c_left >= tkh_pkg::CW'(kept)) begin
          mem_we     = 1'b1;
          state_next = tkh_pkg::ST_FINISH;
        end else begin
          child_next = c_left;
          rv_q_next  = c_right < tkh_pkg::CW'(kept);
          mem_re     = 1'b1;
          mem_raddr0 = c_left[tkh_pkg::AW-1:0];
          mem_raddr1 = c_right[tkh_pkg::AW-1:0];
          state_next = tkh_pkg::ST_DN_CMP;
        end
      end

      tkh_pkg::ST_DN_CMP: begin
        // The moving entry stays only when strictly larger than the child.
        mem_we = 1'b1;
        if (cmp.cur_gt) begin
          state_next = tkh_pkg::ST_FINISH;
        end else begin
          mem_wdata  = cmp.pick_b ? rdata1 : rdata0;
          hole_next  = cmp.pick_b ? c_plus(child) : child[tkh_pkg::AW-1:0];
          state_next = tkh_pkg::ST_DN_RD;
        end
      end

      tkh_pkg::ST_FINISH: begin
        if (draining || last_q) begin
          draining_next = 1'b1;
          state_next    = tkh_pkg::ST_DR_RD;
        end else begin
          state_next = tkh_pkg::ST_IDLE;
        end
      end

      tkh_pkg::ST_DR_RD: begin
        // Fetch the root and the tail entry together.
        mem_re     = 1'b1;
        mem_raddr1 = kept[tkh_pkg::AW-1:0] - tkh_pkg::AW'(1);
        state_next = tkh_pkg::ST_DR_EMIT;
      end

      tkh_pkg::ST_DR_EMIT: begin
        if (out_free) begin
          res_next.out_distance = rdata0.distance;
          res_next.out_index    = tkh_pkg::CIDX_W'(rdata0.idx);
          res_next.out_last     = (kept == tkh_pkg::KB'(1));
          res_valid_next        = 1'b1;
          kept_next             = kept - tkh_pkg::KB'(1);
          cur_next              = rdata1;
          hole_next             = '0;
          if (kept == tkh_pkg::KB'(1)) begin
            draining_next = 1'b0;
            state_next    = tkh_pkg::ST_IDLE;
          end else begin
            state_next = tkh_pkg::ST_DN_RD;
          end
        end
      end

      default: begin
        state_next = tkh_pkg::ST_IDLE;
      end
    endcase
  end

  // --------------------------------------------------------------------------
`ifndef ASSERT_OFF
  // The fill count never passes the heap capacity.
  a_kept_bound: assert property (@(posedge clk) disable iff (rst)
    kept <= tkh_pkg::KB'(tkh_pkg::MAX_K))
    else $error("heap fill count above capacity");

  // A new result word only appears out of a drain.
  a_res_from_drain: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(draining))
    else $error("result word outside a drain");

  // A stalled drain leaves the heap count alone.
  a_drain_stall: assert property (@(posedge clk) disable iff (rst)
    (state == tkh_pkg::ST_DR_EMIT && res_valid && !res_ready) |=> kept == $past(kept))
    else $error("heap changed while the drain was stalled");

  // No candidate is taken while a drain is in progress.
  a_no_cand_in_drain: assert property (@(posedge clk) disable iff (rst)
    (cand_valid && cand_ready) |-> !draining)
    else $error("candidate accepted during drain");
`endif

endmodule

FILE: rtl/tkh_heap_mem.sv
// ----------------------------------------------------------------------------
// tkh_heap_mem: heap storage
//
// One write port and two read ports with registered read data. The read
// data holds while no read is issued.
// ----------------------------------------------------------------------------
module tkh_heap_mem (
  input  logic                    clk,
  input  logic                    we,
  input  logic [tkh_pkg::AW-1:0]  waddr,
  input  tkh_pkg::entry_t         wdata,
  input  logic                    re,
  input  logic [tkh_pkg::AW-1:0]  raddr0,
  input  logic [tkh_pkg::AW-1:0]  raddr1,
  output tkh_pkg::entry_t         rdata0,
  output tkh_pkg::entry_t         rdata1
);

  tkh_pkg::entry_t mem [tkh_pkg::MAX_K];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Two registered read ports.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata0 <= mem[raddr0];
      rdata1 <= mem[raddr1];
    end
  end

endmodule

FILE: rtl/tkh_cmp.sv
// ----------------------------------------------------------------------------
// tkh_cmp: shared distance compare unit
//
// Picks the larger of two heap entries (the second only when it is valid
// and strictly larger) and compares the moving entry against the pick.
// ----------------------------------------------------------------------------
module tkh_cmp (
  input  logic [tkh_pkg::DIST_W-1:0] cur_dist,
  input  logic [tkh_pkg::DIST_W-1:0] a_dist,
  input  logic [tkh_pkg::DIST_W-1:0] b_dist,
  input  logic                       b_valid,
  output tkh_pkg::cmp_res_t          res
);

  logic [tkh_pkg::DIST_W-1:0] sel_dist;

  // Child select: the right child wins only when strictly larger.
  assign res.pick_b = b_valid && (b_dist > a_dist);
  assign sel_dist   = res.pick_b ? b_dist : a_dist;

  // Order of the moving entry against the selected entry.
  assign res.cur_gt = cur_dist > sel_dist;
  assign res.cur_lt = cur_dist < sel_dist;

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for top_k_smallest_max_heap
//
// Streams candidate words through the heap selector and compares every
// drained result word with a behavioral max-heap kept in the bench. A short
// table of directed rows covers the extremes, ties, the K register limits and
// a K change in the middle of a query. Random queries follow under three
// idling patterns of sender and receiver.
// ----------------------------------------------------------------------------
module testbench;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 40;
  localparam int PHASE_ITEMS    = 46;
  localparam logic [tkh_pkg::CIDX_W-1:0] IDX_MASK =
    tkh_pkg::CIDX_W'((64'd1 << tkh_pkg::IDX_KEEP) - 1);
  localparam logic [tkh_pkg::PADDR_W-1:0] K_ADDR =
    tkh_pkg::PADDR_W'(4 * tkh_pkg::REG_K_IDX);

  typedef enum logic {ROW_CAND, ROW_SET_K} row_kind_t;

  // One row of the directed table.
  typedef struct {
    row_kind_t           kind;
    logic [4:0]          k_val;
    tkh_pkg::cand_word_t word;
    bit                  known;
    tkh_pkg::res_word_t  known_res;
  } stim_row_t;

  logic                       clk = 1'b0;
  logic                       rst;
  logic                       cand_valid;
  logic                       cand_ready;
  tkh_pkg::cand_word_t        cand;
  logic                       res_valid;
  logic                       res_ready;
  tkh_pkg::res_word_t         res;
  logic                       psel;
  logic                       penable;
  logic                       pwrite;
  logic [tkh_pkg::PADDR_W-1:0] paddr;
  logic [31:0]                pwdata;
  logic [31:0]                prdata;
  logic                       pready;

  // Behavioral heap of the kept neighbors and the configured K.
  logic [tkh_pkg::DIST_W-1:0] heap_d [tkh_pkg::MAX_K];
  logic [tkh_pkg::CIDX_W-1:0] heap_i [tkh_pkg::MAX_K];
  int unsigned                heap_fill;
  logic [tkh_pkg::KCFG_W-1:0] k_setting;

  tkh_pkg::res_word_t expected_neighbors[$];
  stim_row_t          directed_rows[$];
  int                 error_count;
  int                 send_idle_pct;
  int                 recv_idle_pct;
  int                 stall_cycles;

  top_k_smallest_max_heap DUT (
    .clk        (clk),
    .rst        (rst),
    .cand_valid (cand_valid),
    .cand_ready (cand_ready),
    .cand       (cand),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always #5 clk = ~clk;

  // Swap two heap entries.
  function automatic void heap_swap(int a, int b);
    logic [tkh_pkg::DIST_W-1:0] td;
    logic [tkh_pkg::CIDX_W-1:0] ti;
    td = heap_d[a];
    ti = heap_i[a];
    heap_d[a] = heap_d[b];
    heap_i[a] = heap_i[b];
    heap_d[b] = td;
    heap_i[b] = ti;
  endfunction

  // Move the entry at position p up while it is strictly larger than its parent.
  function automatic void heap_sift_up(int p);
    int parent;
    while (p > 0) begin
      parent = (p - 1) / 2;
      if (!(heap_d[p] > heap_d[parent])) break;
      heap_swap(p, parent);
      p = parent;
    end
  endfunction

  // Move the root down through the first n entries; equal distances swap.
  function automatic void heap_sift_down(int n);
    int p;
    int c;
    p = 0;
    while (2 * p + 1 < n) begin
      c = 2 * p + 1;
      if (c + 1 < n && heap_d[c + 1] > heap_d[c]) c = c + 1;
      if (heap_d[p] > heap_d[c]) break;
      heap_swap(p, c);
      p = c;
    end
  endfunction

  // Apply one accepted candidate to the heap and queue the neighbors it drains.
  function automatic void admit_candidate(tkh_pkg::cand_word_t w);
    int unsigned        k_eff;
    tkh_pkg::res_word_t r;
    if (k_setting == 0) k_eff = 1;
    else if (k_setting > tkh_pkg::MAX_K) k_eff = tkh_pkg::MAX_K;
    else k_eff = k_setting;

    if (heap_fill < k_eff) begin
      heap_d[heap_fill] = w.cand_distance;
      heap_i[heap_fill] = w.cand_index & IDX_MASK;
      heap_fill++;
      heap_sift_up(heap_fill - 1);
    end else if (heap_fill > 0 && w.cand_distance < heap_d[0]) begin
      heap_d[0] = w.cand_distance;
      heap_i[0] = w.cand_index & IDX_MASK;
      heap_sift_down(heap_fill);
    end

    if (w.query_end) begin
      while (heap_fill > 0) begin
        r.out_distance = heap_d[0];
        r.out_index    = heap_i[0];
        r.out_last     = (heap_fill == 1);
        expected_neighbors.push_back(r);
        heap_d[0] = heap_d[heap_fill - 1];
        heap_i[0] = heap_i[heap_fill - 1];
        heap_fill--;
        heap_sift_down(heap_fill);
      end
    end
  endfunction

  // Offer one candidate word; when known is set, the typed result replaces
  // whatever the heap model predicts for this word.
  task automatic push_cand(tkh_pkg::cand_word_t w, bit known,
                           tkh_pkg::res_word_t known_res);
    int n0;
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      cand_valid <= 1'b0;
      @(negedge clk);
    end
    cand_valid <= 1'b1;
    cand       <= w;
    do @(posedge clk); while (!cand_ready);
    n0 = expected_neighbors.size();
    admit_candidate(w);
    if (known) begin
      while (expected_neighbors.size() > n0) void'(expected_neighbors.pop_back());
      expected_neighbors.push_back(known_res);
    end
  endtask

  // Stop sending, wait for every pending result and let the sequencer settle.
  task automatic wait_idle();
    @(negedge clk);
    cand_valid <= 1'b0;
    while (expected_neighbors.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write k_in_use through the register port: setup cycle, then access cycle.
  task automatic write_k(logic [tkh_pkg::KCFG_W-1:0] v);
    @(negedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= K_ADDR;
    pwdata  <= 32'(v);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    k_setting = v;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  function automatic stim_row_t cand_row(logic [31:0] d, logic [19:0] ix, bit qe);
    stim_row_t r;
    r.kind      = ROW_CAND;
    r.k_val     = '0;
    r.word      = '{cand_distance: d, cand_index: ix, query_end: qe};
    r.known     = 1'b0;
    r.known_res = '0;
    return r;
  endfunction

  // Row that ends a query with exactly one kept neighbor: (kd, ki).
  function automatic stim_row_t known_row(logic [31:0] d, logic [19:0] ix,
                                          logic [31:0] kd, logic [19:0] ki);
    stim_row_t r;
    r           = cand_row(d, ix, 1'b1);
    r.known     = 1'b1;
    r.known_res = '{out_distance: kd, out_index: ki, out_last: 1'b1};
    return r;
  endfunction

  function automatic stim_row_t k_row(logic [4:0] v);
    stim_row_t r;
    r       = cand_row('0, '0, 1'b0);
    r.kind  = ROW_SET_K;
    r.k_val = v;
    return r;
  endfunction

  // Distances: full range, a narrow band that forces ties, or the extremes.
  function automatic logic [31:0] pick_distance(int mode);
    case (mode)
      0: return $urandom;
      1: return $urandom_range(0, 15);
      default: begin
        case ($urandom_range(0, 2))
          0: return 32'h0;
          1: return 32'hFFFF_FFFF;
          default: return $urandom;
        endcase
      end
    endcase
  endfunction

  // Receiver: ready drops at random according to the current pattern.
  always @(negedge clk) begin
    res_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Result checker: compare each accepted word with the oldest expectation.
  always @(posedge clk) begin
    tkh_pkg::res_word_t want;
    if (!rst && res_valid && res_ready) begin
      if (expected_neighbors.size() == 0) begin
        $error("unexpected result word: distance %h index %h last %b",
               res.out_distance, res.out_index, res.out_last);
        error_count++;
      end else begin
        want = expected_neighbors.pop_front();
        if (res.out_distance !== want.out_distance) begin
          $error("out_distance: expected %h, got %h", want.out_distance, res.out_distance);
          error_count++;
        end
        if (res.out_index !== want.out_index) begin
          $error("out_index: expected %h, got %h", want.out_index, res.out_index);
          error_count++;
        end
        if (res.out_last !== want.out_last) begin
          $error("out_last: expected %b, got %b", want.out_last, res.out_last);
          error_count++;
        end
      end
    end
  end

  // Watchdog: count cycles in which no word moves on either channel.
  always @(posedge clk) begin
    if (rst || (cand_valid && cand_ready) || (res_valid && res_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    stim_row_t           row;
    int                  phase;
    int                  sent;
    int                  qlen;
    int                  mode;
    tkh_pkg::cand_word_t w;

    rst           = 1'b1;
    cand_valid    = 1'b0;
    cand          = '0;
    res_ready     = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    error_count   = 0;
    stall_cycles  = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    heap_fill     = 0;
    k_setting     = tkh_pkg::K_RESET;
    for (int i = 0; i < tkh_pkg::MAX_K; i++) begin
      heap_d[i] = '0;
      heap_i[i] = '0;
    end

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed table. Single-candidate queries under the reset K.
    directed_rows.push_back(known_row(32'h5, 20'h3, 32'h5, 20'h3));
    directed_rows.push_back(known_row(32'hFFFF_FFFF, 20'hF_FFFF, 32'hFFFF_FFFF, 20'hF_FFFF));
    directed_rows.push_back(known_row(32'h0, 20'h0, 32'h0, 20'h0));
    // K of one keeps the minimum; a candidate equal to the root is dropped.
    directed_rows.push_back(k_row(5'd1));
    directed_rows.push_back(cand_row(32'd100, 20'h1, 1'b0));
    directed_rows.push_back(cand_row(32'd50, 20'h2, 1'b0));
    directed_rows.push_back(cand_row(32'd50, 20'h3, 1'b0));
    directed_rows.push_back(known_row(32'd70, 20'h4, 32'd50, 20'h2));
    // K of zero acts as one.
    directed_rows.push_back(k_row(5'd0));
    directed_rows.push_back(known_row(32'd9, 20'hA_AAAA, 32'd9, 20'hA_AAAA));
    // K above the heap size acts as the heap size; ties in both sift directions.
    directed_rows.push_back(k_row(5'd31));
    directed_rows.push_back(cand_row(32'd7, 20'h1, 1'b0));
    directed_rows.push_back(cand_row(32'd7, 20'h2, 1'b0));
    directed_rows.push_back(cand_row(32'd7, 20'h3, 1'b0));
    directed_rows.push_back(cand_row(32'd3, 20'h4, 1'b0));
    directed_rows.push_back(cand_row(32'd10, 20'h5, 1'b0));
    directed_rows.push_back(cand_row(32'd0, 20'h6, 1'b0));
    directed_rows.push_back(cand_row(32'hFFFF_FFFF, 20'h7, 1'b0));
    directed_rows.push_back(cand_row(32'd10, 20'h8, 1'b0));
    // K lowered mid-query: the heap counts as full and drains every entry.
    directed_rows.push_back(k_row(5'd2));
    directed_rows.push_back(cand_row(32'd1, 20'h9, 1'b0));
    directed_rows.push_back(cand_row(32'd8, 20'hA, 1'b0));
    directed_rows.push_back(cand_row(32'd7, 20'hB, 1'b1));
    directed_rows.push_back(k_row(5'd17));
    directed_rows.push_back(cand_row(32'd2, 20'h5_5555, 1'b1));
    directed_rows.push_back(k_row(5'd16));
    directed_rows.push_back(cand_row(32'h8000_0000, 20'h8_0000, 1'b1));

    foreach (directed_rows[n]) begin
      row = directed_rows[n];
      if (row.kind == ROW_SET_K) begin
        wait_idle();
        write_k(row.k_val);
      end else begin
        push_cand(row.word, row.known, row.known_res);
      end
    end

    // Random queries in three idling patterns. A phase may stop mid-query,
    // so the next K setting also lands inside an open query.
    for (phase = 0; phase < 3; phase++) begin
      wait_idle();
      case (phase)
        0: begin
          send_idle_pct = 32;
          recv_idle_pct = 60;
          write_k(tkh_pkg::KCFG_W'($urandom_range(1, 16)));
        end
        1: begin
          send_idle_pct = 60;
          recv_idle_pct = 32;
          write_k(tkh_pkg::KCFG_W'($urandom_range(0, 31)));
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          write_k(tkh_pkg::K_RESET);
        end
      endcase
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        qlen = $urandom_range(1, 24);
        mode = $urandom_range(0, 2);
        for (int j = 0; j < qlen && sent < PHASE_ITEMS; j++) begin
          w.cand_distance = pick_distance(mode);
          w.cand_index    = tkh_pkg::CIDX_W'($urandom);
          w.query_end     = (j == qlen - 1);
          push_cand(w, 1'b0, '0);
          sent++;
        end
        // Now and then hold the sender until the drain has fully arrived.
        if ($urandom_range(0, 9) == 0) wait_idle();
      end
    end

    // Close whatever query is still open.
    w.cand_distance = $urandom;
    w.cand_index    = tkh_pkg::CIDX_W'($urandom);
    w.query_end     = 1'b1;
    push_cand(w, 1'b0, '0);
    wait_idle();

    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/tkh_pkg.sv
rtl/tkh_heap_mem.sv
rtl/tkh_cmp.sv
rtl/top_k_smallest_max_heap.sv
test/testbench.sv
